@@ hdl/tlc_pkg.sv @@
// ----------------------------------------------------------------------------
// tlc_pkg: shared types and constants of the two-level cache tag unit
// Holds the state encodings, status codes, register indexes and sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package tlc_pkg;

  // Default sizes of the tag stores and the address.
  localparam int L1_LINES_DEF  = 256;
  localparam int L2_LINES_DEF  = 1024;
  localparam int ADDR_BITS_DEF = 13;

  // Associativity limit and rank width.
  localparam int MAX_WAYS = 16;
  localparam int RANK_W   = 4;

  // Width of a line index before wrapping: row up to 1023, shifted by 4.
  localparam int IDX_W = 14;
  localparam int BIT_W = 4;

  // Reciprocal of the store size used to reduce a set base. The shift covers
  // a 14-bit base and store sizes up to 8192 lines, so the quotient is exact.
  localparam int RECIP_SH = IDX_W + 13;
  localparam int RECIP_W  = RECIP_SH + 1;

  // Result status codes.
  localparam logic [1:0] STAT_HIT   = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_STORE = 2'd2;
  localparam logic [1:0] STAT_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_L2_ENABLE = 3'd0;
  localparam logic [2:0] REG_L1_WAYS   = 3'd1;
  localparam logic [2:0] REG_L1_BLOCK  = 3'd2;
  localparam logic [2:0] REG_L1_SETS   = 3'd3;
  localparam logic [2:0] REG_L2_WAYS   = 3'd4;
  localparam logic [2:0] REG_L2_BLOCK  = 3'd5;
  localparam logic [2:0] REG_L2_SETS   = 3'd6;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L1,
    ST_L2,
    ST_DONE
  } top_state_t;

  // Lookup engine states.
  typedef enum logic [2:0] {
    E_IDLE,
    E_MOD,
    E_SRD,
    E_SEV,
    E_URD,
    E_UWR,
    E_DONE
  } eng_state_t;

  // Memory request from the lookup engine.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] line;
  } mem_req_t;

endpackage

`default_nettype wire

@@ hdl/tlc_store.sv @@
// ----------------------------------------------------------------------------
// tlc_store: tag, valid and rank memory of one cache level
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_store #(
  parameter int LINES = tlc_pkg::L1_LINES_DEF,
  parameter int AW    = 8,
  parameter int DW    = 18
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [LINES];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/tlc_lookup.sv @@
// ----------------------------------------------------------------------------
// tlc_lookup: shared set lookup engine
// Reduces the set base modulo the store size, scans the ways for a hit and
// the LRU victim, then rewrites the ranks and fills the victim on a miss.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_lookup #(
  parameter int ADDR_BITS = tlc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [2:0]                  ways_log2,
  input  wire logic [9:0]                  row,
  input  wire logic [ADDR_BITS-1:0]        tag,
  input  wire logic [tlc_pkg::IDX_W-1:0]   lines,
  input  wire logic [tlc_pkg::RECIP_W-1:0] recip,
  input  wire logic [ADDR_BITS+4:0]        rd_data,
  output tlc_pkg::mem_req_t                req,
  output logic      [ADDR_BITS+4:0]        wr_data,
  output logic                             done,
  output logic                             hit
);

  localparam int IW = tlc_pkg::IDX_W;
  localparam int RW = tlc_pkg::RANK_W;
  localparam int BW = tlc_pkg::BIT_W;
  localparam int MW = tlc_pkg::RECIP_W;

  tlc_pkg::eng_state_t st_r, st_nxt;

  logic [IW-1:0]      base_r;
  logic [IW-1:0]      rem_r;
  logic [IW-1:0]      quo_r;
  logic [BW-1:0]      bitc_r;
  logic [IW-1:0]      li_r;
  logic [RW-1:0]      w_r;
  logic               hit_r;
  logic [RW-1:0]      hitw_r, hrank_r, vic_r, vrank_r;

  logic [RW-1:0]      ways_m1;
  logic [IW+MW-1:0]   quo_prod;
  logic [2*IW-1:0]    back_prod;
  logic [IW-1:0]      mod_res;
  logic [IW-1:0]      li_inc;
  logic               last_way;
  logic               e_valid;
  logic [ADDR_BITS-1:0] e_tag;
  logic [RW-1:0]      e_rank;
  logic [RW-1:0]      chosen, old_rank;

  assign ways_m1   = RW'((5'd1 << ways_log2) - 5'd1);
  assign last_way  = (w_r == ways_m1);
  assign quo_prod  = {{MW{1'b0}}, base_r} * {{IW{1'b0}}, recip};
  assign back_prod = {{IW{1'b0}}, quo_r} * {{IW{1'b0}}, lines};
  assign mod_res   = base_r - back_prod[IW-1:0];
  assign li_inc    = ((li_r + IW'(1)) >= lines) ? '0 : (li_r + IW'(1));
  assign e_valid   = rd_data[ADDR_BITS+4];
  assign e_tag     = rd_data[ADDR_BITS+3:4];
  assign e_rank    = rd_data[RW-1:0];
  assign chosen    = hit_r ? hitw_r : vic_r;
  assign old_rank  = hit_r ? hrank_r : vrank_r;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tlc_pkg::E_IDLE: if (start) st_nxt = tlc_pkg::E_MOD;
      tlc_pkg::E_MOD:  if (bitc_r == '0) st_nxt = tlc_pkg::E_SRD;
      tlc_pkg::E_SRD:  st_nxt = tlc_pkg::E_SEV;
      tlc_pkg::E_SEV:  st_nxt = last_way ? tlc_pkg::E_URD : tlc_pkg::E_SRD;
      tlc_pkg::E_URD:  st_nxt = tlc_pkg::E_UWR;
      tlc_pkg::E_UWR:  st_nxt = last_way ? tlc_pkg::E_DONE : tlc_pkg::E_URD;
      tlc_pkg::E_DONE: st_nxt = tlc_pkg::E_IDLE;
      default:         st_nxt = tlc_pkg::E_IDLE;
    endcase
  end

  // Outputs: memory request and write-back data.
  always_comb begin
    req.wr_en = (st_r == tlc_pkg::E_UWR);
    req.line  = li_r;
    done      = (st_r == tlc_pkg::E_DONE);
    hit       = hit_r;
    wr_data   = rd_data;
    if (w_r == chosen) begin
      wr_data[RW-1:0] = ways_m1;
      if (!hit_r) begin
        wr_data[ADDR_BITS+4]   = 1'b1;
        wr_data[ADDR_BITS+3:4] = tag;
      end
    end else if (e_rank > old_rank) begin
      wr_data[RW-1:0] = e_rank - RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tlc_pkg::E_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Datapath: modulo reduction, way scan and rank update.
  always_ff @(posedge clk) begin
    case (st_r)
      tlc_pkg::E_IDLE: begin
        base_r <= IW'({4'd0, row} << ways_log2);
        bitc_r <= BW'(1);
        hit_r  <= 1'b0;
        w_r    <= '0;
      end
      tlc_pkg::E_MOD: begin
        // First the quotient by reciprocal multiplication, then the remainder.
        if (bitc_r != '0) begin
          quo_r <= IW'(quo_prod >> tlc_pkg::RECIP_SH);
        end else begin
          rem_r <= mod_res;
          li_r  <= mod_res;
        end
        bitc_r <= bitc_r - BW'(1);
      end
      tlc_pkg::E_SEV: begin
        if (!hit_r && e_valid && e_tag == tag) begin
          hit_r   <= 1'b1;
          hitw_r  <= w_r;
          hrank_r <= e_rank;
        end
        if (w_r == '0 || e_rank < vrank_r) begin
          vic_r   <= w_r;
          vrank_r <= e_rank;
        end
        if (last_way) begin
          w_r  <= '0;
          li_r <= rem_r;
        end else begin
          w_r  <= w_r + RW'(1);
          li_r <= li_inc;
        end
      end
      tlc_pkg::E_UWR: begin
        w_r  <= w_r + RW'(1);
        li_r <= li_inc;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/two_level_lru_cache_tags_unit.sv @@
// ----------------------------------------------------------------------------
// two_level_lru_cache_tags_unit: tag model of an L1 and optional L2 cache
// Classifies each load or store as hit, miss or store per level, true LRU.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_kind and in_addr with start high while busy is low; the request
//   is taken at that edge and busy stays high until its result has been shown.
//   The result appears on the out_ ports for one cycle with out_valid high;
//   the receiver cannot stall, so it must take it in that cycle.
//   Each level lookup runs in the shared engine: a start state, a reciprocal
//   reduction of the set base modulo the store size that forms the quotient
//   and then the remainder, a scan pass and an update pass with a read and an
//   evaluate or write state per way on the registered store port, and a done
//   state. The result is shown in the cycle after the engine's done state of
//   the last lookup, and busy drops in the cycle after that; an L2 lookup adds
//   a second engine pass over L2. One request at a time.
//   Configuration writes go through cfg_valid/cfg_ready; ready is high when
//   idle with start low and during a clearing pass. A write to a known
//   register, and reset, start a clearing pass over max(L1_LINES, L2_LINES)
//   addresses that invalidates all lines and restores the rank order; busy is
//   high during it. Writes past the register list are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_lru_cache_tags_unit #(
  parameter int L1_LINES  = tlc_pkg::L1_LINES_DEF,
  parameter int L2_LINES  = tlc_pkg::L2_LINES_DEF,
  parameter int ADDR_BITS = tlc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_kind,
  input  wire logic [ADDR_BITS-1:0] in_addr,
  output logic                      out_valid,
  output logic [1:0]                out_l1_status,
  output logic [7:0]                out_l1_row,
  output logic [1:0]                out_l2_status,
  output logic [9:0]                out_l2_row,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [3:0]           cfg_data
);

  localparam int IW    = tlc_pkg::IDX_W;
  localparam int MW    = tlc_pkg::RECIP_W;
  localparam int DW    = ADDR_BITS + 5;
  localparam int L1_AW = (L1_LINES > 1) ? $clog2(L1_LINES) : 1;
  localparam int L2_AW = (L2_LINES > 1) ? $clog2(L2_LINES) : 1;
  localparam int CLR_N = (L1_LINES > L2_LINES) ? L1_LINES : L2_LINES;
  localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  // Rounded-up reciprocals of the store sizes for the line index reduction.
  localparam logic [MW-1:0] L1_RECIP = MW'(((longint'(1) << tlc_pkg::RECIP_SH)
                                        + longint'(L1_LINES) - longint'(1))
                                        / longint'(L1_LINES));
  localparam logic [MW-1:0] L2_RECIP = MW'(((longint'(1) << tlc_pkg::RECIP_SH)
                                        + longint'(L2_LINES) - longint'(1))
                                        / longint'(L2_LINES));

  tlc_pkg::top_state_t st_r, st_nxt;

  // Configuration registers.
  logic       l2_en_r;
  logic [2:0] l1_wl_r, l1_bl_r, l2_wl_r, l2_bl_r;
  logic [3:0] l1_sl_r, l2_sl_r;

  logic                 kind_r, h1_r, go_r, lvl_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [CLR_W-1:0]     clr_r;
  logic [1:0]           l1_stat_r, l2_stat_r;
  logic [9:0]           l2_row_r;

  logic                 cfg_wr, cfg_known, accept;
  logic [2:0]           w1, w2, b1s, b2s;
  logic [3:0]           s1, s2;
  logic [ADDR_BITS-1:0] blk1, blk2, tag1, tag2;
  logic [7:0]           row1;
  logic [9:0]           row2;
  logic                 clr_last;

  tlc_pkg::mem_req_t    req;
  logic [DW-1:0]        eng_wdata, rd1, rd2, rdsel;
  logic                 eng_done, eng_hit;

  logic                 l1_we, l2_we;
  logic [L1_AW-1:0]     l1_wa, l1_ra;
  logic [L2_AW-1:0]     l2_wa, l2_ra;
  logic [DW-1:0]        l1_wd, l2_wd;

  assign cfg_ready = (st_r == tlc_pkg::ST_CLEAR) || (st_r == tlc_pkg::ST_IDLE && !start);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_known = cfg_wr
                  && (cfg_index inside {[tlc_pkg::REG_L2_ENABLE:tlc_pkg::REG_L2_SETS]});
  assign accept    = start && !busy;
  assign clr_last  = (clr_r == CLR_W'(CLR_N - 1));

  // Saturated geometry and address decode.
  assign w1   = (l1_wl_r > 3'd4) ? 3'd4 : l1_wl_r;
  assign w2   = (l2_wl_r > 3'd4) ? 3'd4 : l2_wl_r;
  assign b1s  = (l1_bl_r > 3'd6) ? 3'd6 : l1_bl_r;
  assign b2s  = (l2_bl_r > 3'd6) ? 3'd6 : l2_bl_r;
  assign s1   = (l1_sl_r > 4'd8) ? 4'd8 : l1_sl_r;
  assign s2   = (l2_sl_r > 4'd10) ? 4'd10 : l2_sl_r;
  assign blk1 = addr_r >> b1s;
  assign blk2 = addr_r >> b2s;
  assign row1 = 8'(blk1 & ((ADDR_BITS'(1) << s1) - ADDR_BITS'(1)));
  assign row2 = 10'(blk2 & ((ADDR_BITS'(1) << s2) - ADDR_BITS'(1)));
  assign tag1 = blk1 >> s1;
  assign tag2 = blk2 >> s2;

  // Shared lookup engine, pointed at one level at a time.
  tlc_lookup #(
    .ADDR_BITS(ADDR_BITS)
  ) u_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (go_r),
    .ways_log2 (lvl_r ? w2 : w1),
    .row       (lvl_r ? row2 : {2'd0, row1}),
    .tag       (lvl_r ? tag2 : tag1),
    .lines     (lvl_r ? IW'(L2_LINES) : IW'(L1_LINES)),
    .recip     (lvl_r ? L2_RECIP : L1_RECIP),
    .rd_data   (rdsel),
    .req       (req),
    .wr_data   (eng_wdata),
    .done      (eng_done),
    .hit       (eng_hit)
  );

  assign rdsel = lvl_r ? rd2 : rd1;

  // Store port selection: clearing pass or engine.
  always_comb begin
    l1_ra = req.line[L1_AW-1:0];
    l2_ra = req.line[L2_AW-1:0];
    if (st_r == tlc_pkg::ST_CLEAR) begin
      l1_we = ({1'b0, clr_r} < (CLR_W+1)'(L1_LINES));
      l2_we = ({1'b0, clr_r} < (CLR_W+1)'(L2_LINES));
      l1_wa = L1_AW'(clr_r);
      l2_wa = L2_AW'(clr_r);
      l1_wd = {1'b0, ADDR_BITS'(0), 4'(clr_r) & 4'((5'd1 << w1) - 5'd1)};
      l2_wd = {1'b0, ADDR_BITS'(0), 4'(clr_r) & 4'((5'd1 << w2) - 5'd1)};
    end else begin
      l1_we = req.wr_en && !lvl_r;
      l2_we = req.wr_en && lvl_r;
      l1_wa = req.line[L1_AW-1:0];
      l2_wa = req.line[L2_AW-1:0];
      l1_wd = eng_wdata;
      l2_wd = eng_wdata;
    end
  end

  tlc_store #(.LINES(L1_LINES), .AW(L1_AW), .DW(DW)) u_l1 (
    .clk(clk), .wr_en(l1_we), .wr_addr(l1_wa), .wr_data(l1_wd),
    .rd_addr(l1_ra), .rd_data(rd1)
  );

  tlc_store #(.LINES(L2_LINES), .AW(L2_AW), .DW(DW)) u_l2 (
    .clk(clk), .wr_en(l2_we), .wr_addr(l2_wa), .wr_data(l2_wd),
    .rd_addr(l2_ra), .rd_data(rd2)
  );

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tlc_pkg::ST_CLEAR: if (clr_last && !cfg_known) st_nxt = tlc_pkg::ST_IDLE;
      tlc_pkg::ST_IDLE: begin
        if (cfg_known) begin
          st_nxt = tlc_pkg::ST_CLEAR;
        end else if (accept) begin
          st_nxt = tlc_pkg::ST_L1;
        end
      end
      tlc_pkg::ST_L1: begin
        if (eng_done) begin
          st_nxt = (l2_en_r && (kind_r || !eng_hit)) ? tlc_pkg::ST_L2 : tlc_pkg::ST_DONE;
        end
      end
      tlc_pkg::ST_L2:   if (eng_done) st_nxt = tlc_pkg::ST_DONE;
      tlc_pkg::ST_DONE: st_nxt = tlc_pkg::ST_IDLE;
      default:          st_nxt = tlc_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy          = (st_r != tlc_pkg::ST_IDLE);
    out_valid     = (st_r == tlc_pkg::ST_DONE);
    out_l1_status = l1_stat_r;
    out_l1_row    = row1;
    out_l2_status = l2_stat_r;
    out_l2_row    = l2_row_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= tlc_pkg::ST_CLEAR;
      clr_r   <= '0;
      go_r    <= 1'b0;
      lvl_r   <= 1'b0;
      l2_en_r <= 1'b0;
      l1_wl_r <= '0;
      l1_bl_r <= '0;
      l1_sl_r <= '0;
      l2_wl_r <= '0;
      l2_bl_r <= '0;
      l2_sl_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_known) begin
        clr_r <= '0;
      end else if (st_r == tlc_pkg::ST_CLEAR) begin
        clr_r <= clr_r + CLR_W'(1);
      end
      if (cfg_wr) begin
        case (cfg_index)
          tlc_pkg::REG_L2_ENABLE: l2_en_r <= cfg_data[0];
          tlc_pkg::REG_L1_WAYS:   l1_wl_r <= cfg_data[2:0];
          tlc_pkg::REG_L1_BLOCK:  l1_bl_r <= cfg_data[2:0];
          tlc_pkg::REG_L1_SETS:   l1_sl_r <= cfg_data;
          tlc_pkg::REG_L2_WAYS:   l2_wl_r <= cfg_data[2:0];
          tlc_pkg::REG_L2_BLOCK:  l2_bl_r <= cfg_data[2:0];
          tlc_pkg::REG_L2_SETS:   l2_sl_r <= cfg_data;
          default: begin
          end
        endcase
      end
      // Start the engine on the L1 lookup, and again on the L2 lookup.
      if (st_r == tlc_pkg::ST_IDLE && st_nxt == tlc_pkg::ST_L1) begin
        go_r  <= 1'b1;
        lvl_r <= 1'b0;
      end else if (st_r == tlc_pkg::ST_L1 && st_nxt == tlc_pkg::ST_L2) begin
        go_r  <= 1'b1;
        lvl_r <= 1'b1;
      end else begin
        go_r  <= 1'b0;
      end
    end
  end

  // Request and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= in_kind;
      addr_r    <= in_addr;
      l2_stat_r <= tlc_pkg::STAT_NONE;
      l2_row_r  <= '0;
    end
    if (st_r == tlc_pkg::ST_L1 && eng_done) begin
      h1_r      <= eng_hit;
      l1_stat_r <= kind_r ? tlc_pkg::STAT_STORE
                 : (eng_hit ? tlc_pkg::STAT_HIT : tlc_pkg::STAT_MISS);
    end
    if (st_r == tlc_pkg::ST_L2 && eng_done) begin
      l2_row_r  <= row2;
      l2_stat_r <= kind_r ? tlc_pkg::STAT_STORE
                 : (eng_hit ? tlc_pkg::STAT_HIT : tlc_pkg::STAT_MISS);
    end
  end

`ifndef SYNTHESIS
  // A result strobe lasts exactly one cycle.
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // The engine finishes only while a level lookup is running.
  a_done_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    eng_done |-> (st_r == tlc_pkg::ST_L1 || st_r == tlc_pkg::ST_L2))
    else $error("lookup finished outside a level lookup");

  // L2 is looked up only when enabled and L1 missed or the request stores.
  a_l2_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == tlc_pkg::ST_L2) |-> (l2_en_r && (kind_r || !h1_r)))
    else $error("L2 lookup without cause");

  // No request is taken during the clearing pass.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == tlc_pkg::ST_CLEAR) |-> busy)
    else $error("ready during clearing pass");
`endif

endmodule

`default_nettype wire

@@ verif/two_level_lru_cache_tags_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_lru_cache_tags_unit_tb: self-checking bench for the cache tag unit
// Issues loads and stores under many cache geometries. A tag tracker mirrors
// both LRU levels, predicts each outcome and checks every result in order.
// ----------------------------------------------------------------------------

// Outcome of one access as the block should report it.
typedef struct {
  logic [1:0] l1_status;
  logic [7:0] l1_row;
  logic [1:0] l2_status;
  logic [9:0] l2_row;
} access_outcome_t;

// Mirror of both tag stores with true LRU ranks.
class lru_tag_tracker;
  bit          l2_on;
  bit [2:0]    ways_log2[2];
  bit [2:0]    block_log2[2];
  bit [3:0]    sets_log2[2];
  bit          line_valid[2][1024];
  bit [12:0]   line_tag[2][1024];
  bit [3:0]    line_rank[2][1024];
  access_outcome_t pending_outcomes[$];
  int          errors;

  function new();
    l2_on = 0;
    for (int l = 0; l < 2; l++) begin
      ways_log2[l] = 0;
      block_log2[l] = 0;
      sets_log2[l] = 0;
    end
    errors = 0;
    clear_lines();
  endfunction

  function int store_lines(int lvl);
    return (lvl == 0) ? 256 : 1024;
  endfunction

  function int way_total(int lvl);
    return 1 << ((ways_log2[lvl] > 4) ? 4 : ways_log2[lvl]);
  endfunction

  // Invalidate every line and restore the per-set rank order.
  function void clear_lines();
    for (int l = 0; l < 2; l++) begin
      for (int i = 0; i < store_lines(l); i++) begin
        line_valid[l][i] = 0;
        line_rank[l][i] = 4'(i % way_total(l));
      end
    end
  endfunction

  // A write to a known register changes the configuration and empties both caches.
  function void write_reg(logic [2:0] idx, logic [3:0] data);
    case (idx)
      tlc_pkg::REG_L2_ENABLE: l2_on = data[0];
      tlc_pkg::REG_L1_WAYS:   ways_log2[0] = data[2:0];
      tlc_pkg::REG_L1_BLOCK:  block_log2[0] = data[2:0];
      tlc_pkg::REG_L1_SETS:   sets_log2[0] = data;
      tlc_pkg::REG_L2_WAYS:   ways_log2[1] = data[2:0];
      tlc_pkg::REG_L2_BLOCK:  block_log2[1] = data[2:0];
      tlc_pkg::REG_L2_SETS:   sets_log2[1] = data;
      default: return;
    endcase
    clear_lines();
  endfunction

  // Look up one set, touch the hit or victim way; returns 1 on a hit.
  function bit touch_set(int lvl, int row, bit [12:0] tag);
    int base, lines, ways, hit_way, victim, chosen, li, ci;
    bit hit;
    bit [3:0] old_rank;
    lines = store_lines(lvl);
    ways = way_total(lvl);
    base = row * ways;
    hit = 0;
    hit_way = 0;
    victim = 0;
    for (int w = 0; w < ways; w++) begin
      li = (base + w) % lines;
      if (!hit && line_valid[lvl][li] && line_tag[lvl][li] == tag) begin
        hit = 1;
        hit_way = w;
      end
      if (line_rank[lvl][li] < line_rank[lvl][(base + victim) % lines]) victim = w;
    end
    chosen = hit ? hit_way : victim;
    ci = (base + chosen) % lines;
    old_rank = line_rank[lvl][ci];
    for (int w = 0; w < ways; w++) begin
      li = (base + w) % lines;
      if (w != chosen && line_rank[lvl][li] > old_rank)
        line_rank[lvl][li] = line_rank[lvl][li] - 4'd1;
    end
    line_rank[lvl][ci] = 4'(ways - 1);
    if (!hit) begin
      line_valid[lvl][ci] = 1;
      line_tag[lvl][ci] = tag;
    end
    return hit;
  endfunction

  // Note an accepted request and queue the outcome it must produce.
  function void take_request(bit is_store, bit [12:0] addr);
    access_outcome_t o;
    int rows[2];
    bit [12:0] tags[2];
    int blk, sl;
    bit hit1, hit2;
    for (int l = 0; l < 2; l++) begin
      sl = (sets_log2[l] > ((l == 0) ? 8 : 10)) ? ((l == 0) ? 8 : 10) : sets_log2[l];
      blk = addr >> ((block_log2[l] > 6) ? 6 : block_log2[l]);
      rows[l] = blk & ((1 << sl) - 1);
      tags[l] = 13'(blk >> sl);
    end
    hit1 = touch_set(0, rows[0], tags[0]);
    o.l1_status = is_store ? tlc_pkg::STAT_STORE :
                  (hit1 ? tlc_pkg::STAT_HIT : tlc_pkg::STAT_MISS);
    o.l1_row = 8'(rows[0]);
    o.l2_status = tlc_pkg::STAT_NONE;
    o.l2_row = 0;
    if (l2_on && (is_store || !hit1)) begin
      hit2 = touch_set(1, rows[1], tags[1]);
      o.l2_status = is_store ? tlc_pkg::STAT_STORE :
                    (hit2 ? tlc_pkg::STAT_HIT : tlc_pkg::STAT_MISS);
      o.l2_row = 10'(rows[1]);
    end
    pending_outcomes.insert(pending_outcomes.size(), o);
  endfunction

  // Compare one reported outcome with the oldest prediction.
  function void check_outcome(access_outcome_t got);
    access_outcome_t exp;
    if (pending_outcomes.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    exp = pending_outcomes.pop_front();
    if (got.l1_status !== exp.l1_status) begin
      $error("l1_status: expected %0d, got %0d", exp.l1_status, got.l1_status);
      errors++;
    end
    if (got.l1_row !== exp.l1_row) begin
      $error("l1_row: expected %0d, got %0d", exp.l1_row, got.l1_row);
      errors++;
    end
    if (got.l2_status !== exp.l2_status) begin
      $error("l2_status: expected %0d, got %0d", exp.l2_status, got.l2_status);
      errors++;
    end
    if (got.l2_row !== exp.l2_row) begin
      $error("l2_row: expected %0d, got %0d", exp.l2_row, got.l2_row);
      errors++;
    end
  endfunction
endclass

module two_level_lru_cache_tags_unit_tb;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT = 6000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_kind = 0;
  logic [12:0] in_addr = 0;
  logic        out_valid;
  logic [1:0]  out_l1_status;
  logic [7:0]  out_l1_row;
  logic [1:0]  out_l2_status;
  logic [9:0]  out_l2_row;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [3:0]  cfg_data = 0;

  lru_tag_tracker tracker = new();
  bit             allow_gaps = 1;
  int             quiet_cycles = 0;
  logic [12:0]    hot_addr[8];

  two_level_lru_cache_tags_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_addr(in_addr),
    .out_valid(out_valid), .out_l1_status(out_l1_status), .out_l1_row(out_l1_row),
    .out_l2_status(out_l2_status), .out_l2_row(out_l2_row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Observe handshakes at each edge; results are checked before new requests.
  always @(posedge clk) begin
    access_outcome_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.l1_status = out_l1_status;
        got.l1_row = out_l1_row;
        got.l2_status = out_l2_status;
        got.l2_row = out_l2_row;
        tracker.check_outcome(got);
      end
      if (start && !busy) tracker.take_request(in_kind, in_addr);
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
    end
  end

  // Watchdog on cycles with no handshake of any kind.
  always @(posedge clk) begin
    if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one request and return at the edge that accepts it.
  task automatic send_access(bit is_store, logic [12:0] addr);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1;
    in_kind <= is_store;
    in_addr <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drain outstanding results, then write one register.
  task automatic write_reg(logic [2:0] idx, logic [3:0] data);
    start <= 0;
    @(posedge clk);
    while (tracker.pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // Random traffic that mostly revisits a few hot addresses.
  task automatic random_traffic(int count);
    logic [12:0] a;
    for (int i = 0; i < 8; i++) hot_addr[i] = 13'($urandom_range(0, 8191));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7)
        a = hot_addr[$urandom_range(0, 7)] ^ 13'($urandom_range(0, 3));
      else
        a = 13'($urandom_range(0, 8191));
      send_access($urandom_range(0, 3) == 0, a);
    end
  endtask

  initial begin
    logic [3:0] setting[7];
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // Default geometry: one way, one set, L2 off; miss, hit, then store.
    send_access(0, 13'd0);
    send_access(0, 13'd0);
    send_access(0, 13'd8191);
    send_access(1, 13'd8191);
    send_access(0, 13'd8191);

    // An index past the register list must leave the caches untouched.
    write_reg(REG_UNUSED, 4'd15);
    send_access(0, 13'd8191);

    // Two ways, two sets, L2 on: fill, evict, L2 hits and stores.
    write_reg(tlc_pkg::REG_L2_ENABLE, 4'd1);
    write_reg(tlc_pkg::REG_L1_WAYS, 4'd1);
    write_reg(tlc_pkg::REG_L1_SETS, 4'd1);
    send_access(0, 13'd0);
    send_access(0, 13'd2);
    send_access(0, 13'd0);
    send_access(0, 13'd4);
    send_access(0, 13'd2);
    send_access(1, 13'd6);
    send_access(1, 13'd0);
    send_access(0, 13'd6);
    send_access(0, 13'd8191);
    send_access(1, 13'd8190);
    send_access(0, 13'd4);

    // Phases over many geometries, saturating ones and the extremes first.
    for (int p = 0; p < 8; p++) begin
      for (int r = 0; r < 7; r++) begin
        case (p)
          0: setting[r] = 4'd15;
          1: setting[r] = (r == 0) ? 4'd1 : 4'd0;
          2: setting[r] = (r == 1 || r == 4) ? 4'd4 : ((r == 3) ? 4'd8 :
                          ((r == 6) ? 4'd10 : ((r == 0) ? 4'd1 : 4'd6)));
          default: setting[r] = 4'($urandom_range(0, 15));
        endcase
      end
      if (p >= 3 && $urandom_range(0, 3) != 0) setting[0][0] = 1;
      for (int r = 0; r < 7; r++) write_reg(3'(r), setting[r]);
      allow_gaps = (p < 7);
      random_traffic(48);
    end

    start <= 0;
    @(posedge clk);
    while (tracker.pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
